@@ design/gpe_pkg.sv @@
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared widths, limits and control types of the Goldbach pair enumerator.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int GPE_VALUE_BITS  = 10;
  localparam int GPE_WHOLE_W     = 10;
  localparam int GPE_SMALL_W     = 9;
  localparam int GPE_LARGE_W     = 10;
  localparam int GPE_MAX_RESULTS = 64;
  localparam int GPE_CNT_W       = 7;

  localparam int GPE_IN_W  = 16;
  localparam int GPE_OUT_W = 32;

  localparam int GPE_SMALL_LO = GPE_WHOLE_W;
  localparam int GPE_LARGE_LO = GPE_WHOLE_W + GPE_SMALL_W;
  localparam int GPE_OUT_USED = GPE_WHOLE_W + GPE_SMALL_W + GPE_LARGE_W;

  typedef struct packed {
    logic we;
    logic wdata;
    logic re_a;
    logic re_b;
  } gpe_mem_ctl_t;

endpackage

@@ design/gpe_flag_mem.sv @@
// ----------------------------------------------------------------------------
// gpe_flag_mem
// Prime flag table: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gpe_flag_mem #(
  parameter int AW = gpe_pkg::GPE_VALUE_BITS
) (
  input  logic                  clk,
  input  gpe_pkg::gpe_mem_ctl_t ctl,
  input  logic [AW-1:0]         waddr,
  input  logic [AW-1:0]         raddr_a,
  input  logic [AW-1:0]         raddr_b,
  output logic                  rdata_a,
  output logic                  rdata_b
);
  import gpe_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic flag_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      flag_mem[waddr] <= ctl.wdata;
    end
    if (ctl.re_a) begin
      rdata_a <= flag_mem[raddr_a];
    end
    if (ctl.re_b) begin
      rdata_b <= flag_mem[raddr_b];
    end
  end

endmodule

@@ design/gpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// gpe_ctrl
// Builds the prime flag table with a sieve after reset, then scans each even
// value for prime pairs and drives the result register.
// ----------------------------------------------------------------------------
module gpe_ctrl #(
  parameter int AW = gpe_pkg::GPE_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [AW-1:0]                     in_value,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gpe_pkg::GPE_WHOLE_W-1:0]   out_whole,
  output logic [gpe_pkg::GPE_SMALL_W-1:0]   out_small,
  output logic [gpe_pkg::GPE_LARGE_W-1:0]   out_large,
  output logic                              out_tlast,
  output gpe_pkg::gpe_mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                     mem_waddr,
  output logic [AW-1:0]                     mem_raddr_a,
  output logic [AW-1:0]                     mem_raddr_b,
  input  logic                              mem_rdata_a,
  input  logic                              mem_rdata_b
);
  import gpe_pkg::*;

  localparam logic [AW-1:0]   MAXV_A = '1;
  localparam logic [AW:0]     MAXV_M = (AW+1)'((1 << AW) - 1);
  localparam logic [2*AW-1:0] MAXV_P = (2*AW)'((1 << AW) - 1);
  localparam logic [AW-1:0]   TWO_A  = AW'(2);
  localparam logic [GPE_CNT_W-1:0] CNT_MAX = GPE_CNT_W'(GPE_MAX_RESULTS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_PREAD,
    ST_PCHECK,
    ST_MARK,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        addr_r;
  logic [AW:0]          mult_r;
  logic [AW-1:0]        v_r;
  logic [AW-1:0]        half_r;
  logic [AW-1:0]        k_r;
  logic [AW-1:0]        hold_k_r;
  logic                 hold_valid_r;
  logic [GPE_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic [GPE_WHOLE_W-1:0] whole_r;
  logic [GPE_SMALL_W-1:0] small_r;
  logic [GPE_LARGE_W-1:0] large_r;
  logic                 last_r;

  logic [2*AW-1:0]      psq;
  logic [AW:0]          mult_nxt;
  logic [AW-1:0]        half_in;
  logic [GPE_CNT_W-1:0] cnt_nxt;
  logic                 found;
  logic                 slot_free;
  logic                 end_scan;
  logic                 out_load;

  assign psq       = addr_r * addr_r;
  assign mult_nxt  = mult_r + (AW+1)'(addr_r);
  assign half_in   = in_value >> 1;
  assign cnt_nxt   = cnt_r + GPE_CNT_W'(1);
  assign found     = mem_rdata_a & mem_rdata_b;
  assign slot_free = !out_valid_r || out_tready;
  assign end_scan  = (k_r == half_r) || (found && (cnt_nxt == CNT_MAX));
  assign out_load  = slot_free && hold_valid_r &&
                     (((state_r == ST_EVAL) && found) || (state_r == ST_FLUSH));

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_whole  = whole_r;
  assign out_small  = small_r;
  assign out_large  = large_r;
  assign out_tlast  = last_r;

  always_comb begin
    mem_ctl     = '0;
    mem_waddr   = addr_r;
    mem_raddr_a = addr_r;
    mem_raddr_b = v_r - k_r;
    case (state_r)
      ST_CLEAR: begin
        mem_ctl.we    = 1'b1;
        mem_ctl.wdata = (addr_r >= TWO_A);
      end
      ST_PREAD: begin
        mem_ctl.re_a = 1'b1;
      end
      ST_MARK: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = mult_r[AW-1:0];
      end
      ST_READ: begin
        mem_ctl.re_a = 1'b1;
        mem_ctl.re_b = 1'b1;
        mem_raddr_a  = k_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      addr_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          if (addr_r == MAXV_A) begin
            addr_r  <= TWO_A;
            state_r <= ST_PREAD;
          end else begin
            addr_r <= addr_r + AW'(1);
          end
        end
        ST_PREAD: begin
          state_r <= ST_PCHECK;
        end
        ST_PCHECK: begin
          if (psq > MAXV_P) begin
            state_r <= ST_IDLE;
          end else if (mem_rdata_a) begin
            mult_r  <= psq[AW:0];
            state_r <= ST_MARK;
          end else begin
            addr_r  <= addr_r + AW'(1);
            state_r <= ST_PREAD;
          end
        end
        ST_MARK: begin
          if (mult_nxt > MAXV_M) begin
            addr_r  <= addr_r + AW'(1);
            state_r <= ST_PREAD;
          end else begin
            mult_r <= mult_nxt;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            v_r          <= in_value;
            half_r       <= half_in;
            k_r          <= TWO_A;
            cnt_r        <= '0;
            hold_valid_r <= 1'b0;
            if (!in_value[0] && (half_in >= TWO_A)) begin
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!(found && hold_valid_r && !slot_free)) begin
            if (found) begin
              if (hold_valid_r) begin
                whole_r     <= GPE_WHOLE_W'(v_r);
                small_r     <= GPE_SMALL_W'(hold_k_r);
                large_r     <= GPE_LARGE_W'(v_r - hold_k_r);
                last_r      <= 1'b0;
              end
              hold_k_r     <= k_r;
              hold_valid_r <= 1'b1;
              cnt_r        <= cnt_nxt;
            end
            if (end_scan) begin
              state_r <= ST_FLUSH;
            end else begin
              k_r     <= k_r + AW'(1);
              state_r <= ST_READ;
            end
          end
        end
        ST_FLUSH: begin
          if (!hold_valid_r) begin
            state_r <= ST_IDLE;
          end else if (slot_free) begin
            whole_r      <= GPE_WHOLE_W'(v_r);
            small_r      <= GPE_SMALL_W'(hold_k_r);
            large_r      <= GPE_LARGE_W'(v_r - hold_k_r);
            last_r       <= 1'b1;
            hold_valid_r <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/goldbach_pair_enumerator.sv @@
// ----------------------------------------------------------------------------
// goldbach_pair_enumerator
// Splits an even value into all pairs of primes that sum to it, up to 64,
// smaller prime ascending, with the last pair of each value marked.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_      slave      value
//  out_     master     whole, small_prime, large_prime; last on tlast
//
// After reset the block fills a prime flag table: a clearing pass over all
// 2**VALUE_BITS entries, then a sieve that reads each candidate below the
// square root of the range and writes one multiple per cycle. No input
// transfer is taken during that time. An even value then has each candidate
// k from 2 to value/2 read and then checked on the flag memory, ending in a
// flush of the held pair; odd values and values below 4 are taken and dropped.
// The scan stalls when a new pair is found while the held pair cannot enter
// a full output register.
module goldbach_pair_enumerator #(
  parameter int VALUE_BITS = gpe_pkg::GPE_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // value [9:0]
  input  logic [gpe_pkg::GPE_IN_W-1:0] in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // whole [9:0], small_prime [18:10], large_prime [28:19]
  output logic [gpe_pkg::GPE_OUT_W-1:0] out_tdata,
  output logic                         out_tlast
);
  import gpe_pkg::*;

  gpe_mem_ctl_t            mem_ctl;
  logic [VALUE_BITS-1:0]   mem_waddr;
  logic [VALUE_BITS-1:0]   mem_raddr_a;
  logic [VALUE_BITS-1:0]   mem_raddr_b;
  logic                    mem_rdata_a;
  logic                    mem_rdata_b;
  logic [GPE_WHOLE_W-1:0]  whole;
  logic [GPE_SMALL_W-1:0]  small_prime;
  logic [GPE_LARGE_W-1:0]  large_prime;

  gpe_flag_mem #(
    .AW(VALUE_BITS)
  ) u_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .waddr  (mem_waddr),
    .raddr_a(mem_raddr_a),
    .raddr_b(mem_raddr_b),
    .rdata_a(mem_rdata_a),
    .rdata_b(mem_rdata_b)
  );

  gpe_ctrl #(
    .AW(VALUE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_value   (in_tdata[VALUE_BITS-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_whole  (whole),
    .out_small  (small_prime),
    .out_large  (large_prime),
    .out_tlast  (out_tlast),
    .mem_ctl    (mem_ctl),
    .mem_waddr  (mem_waddr),
    .mem_raddr_a(mem_raddr_a),
    .mem_raddr_b(mem_raddr_b),
    .mem_rdata_a(mem_rdata_a),
    .mem_rdata_b(mem_rdata_b)
  );

  assign out_tdata = {(GPE_OUT_W - GPE_OUT_USED)'(0), large_prime, small_prime, whole};

endmodule

@@ design/gpe_checker.sv @@
// ----------------------------------------------------------------------------
// gpe_checker
// Port-level checks of the Goldbach pair enumerator, bound to the top level.
// ----------------------------------------------------------------------------
module gpe_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [gpe_pkg::GPE_OUT_W-1:0] out_tdata,
  input logic                          out_tlast
);
  import gpe_pkg::*;

  logic [GPE_WHOLE_W-1:0] whole;
  logic [GPE_SMALL_W-1:0] small_prime;
  logic [GPE_LARGE_W-1:0] large_prime;

  assign whole       = out_tdata[GPE_WHOLE_W-1:0];
  assign small_prime = out_tdata[GPE_SMALL_LO +: GPE_SMALL_W];
  assign large_prime = out_tdata[GPE_LARGE_LO +: GPE_LARGE_W];

  // A pending result is held until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  // The two primes always sum to the echoed value.
  a_pair_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (GPE_LARGE_W'(small_prime) + large_prime) == GPE_LARGE_W'(whole))
    else $error("pair does not sum to whole");

  // Only even values are split, smaller prime first.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !whole[0] && (GPE_LARGE_W'(small_prime) <= large_prime))
    else $error("odd value or misordered pair");

  // While a pair that is not the last waits, no new value is taken.
  a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken before the last pair was produced");

endmodule

bind goldbach_pair_enumerator gpe_checker u_gpe_checker (.*);
